[sv/spq_pkg.sv]
// Shared types and codes for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; no dependencies.
package spq_pkg;

  // Default number of cells in the sorted chain
  localparam int SPQ_DEPTH = 16;

  // Request codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } spq_status_t;

  // One held entry
  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]         prio;
  } entry_t;

  // Request transfer payload
  typedef struct packed {
    logic               req_type;
    logic signed [31:0] item_value;
    logic [7:0]         item_priority;
  } req_t;

  // Result transfer payload
  typedef struct packed {
    logic signed [31:0] out_value;
    logic [7:0]         out_priority;
    logic               out_valid;
    spq_status_t        status;
    logic [4:0]         entry_count;
    logic               is_empty;
  } rsp_t;

  // Broadcast control from the queue controller to every cell
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cell_ctl_t;

endpackage

[sv/sorted_priority_queue.sv]
// Sorted priority queue built as a chain of insert/shift cells.
// Uses spq_pkg and spq_cell.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------
//  req     | in        | req_valid, req_stall | req (req_t)
//  rsp     | out       | rsp_valid, rsp_stall | rsp (rsp_t)
//
// Each request is handled at its transfer: all cells compare against the new priority
// in parallel and shift or load at the transfer edge, and the result is loaded into
// the output register at that same edge.
// A new request is taken in the same cycle the held result is taken.
// Reset clears the fill count and the output register valid; cell contents
// are left as they are and only cells below the fill count are read.
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output spq_pkg::rsp_t rsp
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;
  logic             accept;
  logic             full;
  logic             empty;
  cell_ctl_t        ctl;
  entry_t           slot [QUEUE_DEPTH];
  logic             after [QUEUE_DEPTH];
  rsp_t             rsp_next;
  logic [4:0]       count_ext;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = (fill_count == CNT_W'(QUEUE_DEPTH));
  assign empty     = (fill_count == '0);

  // Broadcast control to the chain
  always_comb begin
    ctl.enq       = accept && (req.req_type == REQ_ENQ) && !full;
    ctl.deq       = accept && (req.req_type == REQ_DEQ) && !empty;
    ctl.item.value = req.item_value;
    ctl.item.prio  = req.item_priority;
  end

  // Cell chain, head in cell 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic   occ;
    logic   l_after;
    entry_t l_slot;
    entry_t r_slot;

    assign occ = IDX < fill_count;
    if (i == 0) begin : g_head
      assign l_after = 1'b1;
      assign l_slot  = ctl.item;
    end else begin : g_body
      assign l_after = after[i-1];
      assign l_slot  = slot[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_slot = ctl.item;
    end else begin : g_inner
      assign r_slot = slot[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ),
      .left_after (l_after),
      .left_slot  (l_slot),
      .right_slot (r_slot),
      .after      (after[i]),
      .slot       (slot[i])
    );
  end

  // Result and count for the request in flight
  always_comb begin
    fill_count_next = fill_count;
    if (ctl.enq) begin
      fill_count_next = fill_count + CNT_W'(1);
    end else if (ctl.deq) begin
      fill_count_next = fill_count - CNT_W'(1);
    end
    count_ext = 5'(fill_count_next);

    rsp_next.out_value    = '0;
    rsp_next.out_priority = '0;
    rsp_next.out_valid    = 1'b0;
    rsp_next.status       = ST_OK;
    case (req.req_type)
      REQ_ENQ: begin
        if (full) begin
          rsp_next.status = ST_OVER;
        end
      end
      REQ_DEQ: begin
        if (empty) begin
          rsp_next.status = ST_UNDER;
        end else begin
          rsp_next.out_value    = slot[0].value;
          rsp_next.out_priority = slot[0].prio;
          rsp_next.out_valid    = 1'b1;
        end
      end
      default: rsp_next.status = ST_OK;
    endcase
    rsp_next.entry_count = count_ext;
    rsp_next.is_empty    = (fill_count_next == '0);
  end

  // Fill count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      rsp_valid  <= accept || (rsp_valid && rsp_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above depth");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    fill_count >= CNT_W'(2) |-> slot[0].prio <= slot[1].prio)
    else $error("head entries out of order");

  a_deq_pops: assert property (@(posedge clk) disable iff (rst)
    accept && (req.req_type == REQ_DEQ) && !empty |=>
      rsp_valid && rsp.out_valid && (fill_count + CNT_W'(1) == $past(fill_count)))
    else $error("dequeue did not remove head");

  a_under_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_UNDER) |-> !rsp.out_valid && rsp.is_empty)
    else $error("underflow result carries data");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    accept && (req.req_type == REQ_ENQ) && full |=> $stable(fill_count))
    else $error("overflow changed the queue");

endmodule

[sv/spq_cell.sv]
// One cell of the sorted chain: holds a single entry and moves it
// toward the tail on insert or toward the head on removal. Uses spq_pkg.
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  logic              left_after,
  input  spq_pkg::entry_t   left_slot,
  input  spq_pkg::entry_t   right_slot,
  output logic              after,
  output spq_pkg::entry_t   slot
);
  import spq_pkg::*;

  // New item goes behind this entry (ties keep arrival order)
  assign after = occupied && (slot.prio <= ctl.item.prio);

  // Keep, take the new item, or take the neighbor's entry
  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      if (!after) begin
        slot <= left_after ? ctl.item : left_slot;
      end
    end else if (ctl.deq) begin
      slot <= right_slot;
    end
  end

endmodule

[tb/tb_sorted_priority_queue.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sorted_priority_queue: directed table, then random traffic.
// Depends on spq_pkg and the sorted_priority_queue RTL; checks every result transfer.
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH        = SPQ_DEPTH;
  localparam int RANDOM_ITEMS = 1900;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int PRINT_CAP    = 200;

  typedef struct {
    req_t r;
    bit   has_exp;
    rsp_t exp;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  req_t req       = '0;
  logic rsp_stall = 1'b0;
  logic req_stall;
  logic rsp_valid;
  rsp_t rsp;

  // Shadow of the queue contents, head in slot 0
  logic signed [31:0] held_value [DEPTH];
  logic [7:0]         held_prio  [DEPTH];
  int                 held_count = 0;

  rsp_t     expected_rsp [$];
  dir_row_t directed_rows [$];
  int       error_count   = 0;
  int       rsp_seen      = 0;
  int       cycle_count   = 0;
  bit       hold_off_req  = 1'b0;

  sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    if (error_count < PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Sorted insert or head removal on the shadow queue; returns the result it causes
  function automatic rsp_t queue_step(input req_t r);
    rsp_t res;
    int   pos;
    int   k;
    res        = '0;
    res.status = ST_OK;
    if (r.req_type == REQ_ENQ) begin
      if (held_count >= DEPTH) begin
        res.status = ST_OVER;
      end else begin
        pos = 0;
        while (pos < held_count && held_prio[pos] <= r.item_priority) pos++;
        for (k = held_count; k > pos; k--) begin
          held_value[k] = held_value[k-1];
          held_prio[k]  = held_prio[k-1];
        end
        held_value[pos] = r.item_value;
        held_prio[pos]  = r.item_priority;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = ST_UNDER;
    end else begin
      res.out_value    = held_value[0];
      res.out_priority = held_prio[0];
      res.out_valid    = 1'b1;
      for (k = 1; k < held_count; k++) begin
        held_value[k-1] = held_value[k];
        held_prio[k-1]  = held_prio[k];
      end
      held_count--;
    end
    res.entry_count = held_count[4:0];
    res.is_empty    = (held_count == 0);
    return res;
  endfunction

  function automatic req_t mk_req(input logic t, input logic signed [31:0] v,
                                  input logic [7:0] p);
    req_t r;
    r.req_type      = t;
    r.item_value    = v;
    r.item_priority = p;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input logic signed [31:0] v, input logic [7:0] p,
                                  input logic ok, input spq_status_t st,
                                  input logic [4:0] cnt, input logic e);
    rsp_t s;
    s.out_value    = v;
    s.out_priority = p;
    s.out_valid    = ok;
    s.status       = st;
    s.entry_count  = cnt;
    s.is_empty     = e;
    return s;
  endfunction

  function automatic void add_row(input req_t r, input bit has_exp, input rsp_t exp);
    dir_row_t row;
    row.r       = r;
    row.has_exp = has_exp;
    row.exp     = exp;
    directed_rows.push_back(row);
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(input bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one request, hold it until the transfer, then record its expected result.
  // Called at a rising edge; returns at a rising edge.
  task automatic send_request(input req_t r, input bit has_exp, input rsp_t exp,
                              input bit quiet);
    rsp_t pred;
    int   gap;
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = queue_step(r);
    expected_rsp.push_back(has_exp ? exp : pred);
    gap = pick_gap(quiet);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side back-pressure, with one long hold-off on request
  initial begin : rsp_backpressure
    int  n;
    int  iter;
    bit  quiet;
    bit  hold_done;
    iter      = 0;
    quiet     = 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (iter % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      iter++;
      if (hold_off_req && !hold_done) begin
        n         = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        n = pick_gap(quiet);
      end
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing expected", rsp_seen));
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.out_value !== want.out_value)
          report_error($sformatf("result %0d out_value %0d, expected %0d",
                                 rsp_seen, rsp.out_value, want.out_value));
        if (rsp.out_priority !== want.out_priority)
          report_error($sformatf("result %0d out_priority %0d, expected %0d",
                                 rsp_seen, rsp.out_priority, want.out_priority));
        if (rsp.out_valid !== want.out_valid)
          report_error($sformatf("result %0d out_valid %0b, expected %0b",
                                 rsp_seen, rsp.out_valid, want.out_valid));
        if (rsp.status !== want.status)
          report_error($sformatf("result %0d status %0d, expected %0d",
                                 rsp_seen, rsp.status, want.status));
        if (rsp.entry_count !== want.entry_count)
          report_error($sformatf("result %0d entry_count %0d, expected %0d",
                                 rsp_seen, rsp.entry_count, want.entry_count));
        if (rsp.is_empty !== want.is_empty)
          report_error($sformatf("result %0d is_empty %0b, expected %0b",
                                 rsp_seen, rsp.is_empty, want.is_empty));
      end
      rsp_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    int   i;
    int   sent;
    int   blk_len;
    int   enq_pct;
    int   prio_mode;
    bit   quiet;
    bit   held_off;
    req_t r;

    // Empty dequeue, extremes, equal-priority ordering, fill to full, overflow, dequeue from full
    add_row(mk_req(REQ_DEQ, 0, 0), 1, mk_rsp(0, 0, 0, ST_UNDER, 0, 1));
    add_row(mk_req(REQ_ENQ, 32'sh7FFFFFFF, 8'd255), 1, mk_rsp(0, 0, 0, ST_OK, 1, 0));
    add_row(mk_req(REQ_ENQ, 32'sh80000000, 8'd0), 1, mk_rsp(0, 0, 0, ST_OK, 2, 0));
    add_row(mk_req(REQ_ENQ, -32'sd1, 8'd0), 1, mk_rsp(0, 0, 0, ST_OK, 3, 0));
    add_row(mk_req(REQ_DEQ, 0, 0), 1, mk_rsp(32'sh80000000, 8'd0, 1, ST_OK, 2, 0));
    add_row(mk_req(REQ_DEQ, 0, 0), 1, mk_rsp(-32'sd1, 8'd0, 1, ST_OK, 1, 0));
    add_row(mk_req(REQ_DEQ, 0, 0), 1, mk_rsp(32'sh7FFFFFFF, 8'd255, 1, ST_OK, 0, 1));
    for (i = 0; i < DEPTH; i++)
      add_row(mk_req(REQ_ENQ, 32'sh1000 + i, 8'(((i * 3) % 5) * 60)), 0, '0);
    add_row(mk_req(REQ_ENQ, 32'sh5A5A5A5A, 8'd1), 1,
            mk_rsp(0, 0, 0, ST_OVER, 5'(DEPTH), 0));
    add_row(mk_req(REQ_DEQ, 0, 0), 0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k])
      send_request(directed_rows[k].r, directed_rows[k].has_exp, directed_rows[k].exp, 1'b0);

    // Random blocks, each leaning toward filling, draining or balance
    sent     = 0;
    held_off = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      blk_len   = $urandom_range(40, 120);
      case ($urandom_range(0, 2))
        0: enq_pct = 15;
        1: enq_pct = 50;
        default: enq_pct = 85;
      endcase
      prio_mode = $urandom_range(0, 2);
      quiet     = ($urandom_range(0, 3) == 0);
      for (i = 0; i < blk_len && sent < RANDOM_ITEMS; i++) begin
        r.req_type   = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
        case ($urandom_range(0, 7))
          0: r.item_value = 32'sh7FFFFFFF;
          1: r.item_value = 32'sh80000000;
          default: r.item_value = $urandom;
        endcase
        case (prio_mode)
          0: r.item_priority = 8'($urandom_range(0, 255));
          1: r.item_priority = 8'($urandom_range(0, 3));
          default: r.item_priority = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        endcase
        // Long receiver hold-off while requests keep coming
        if (!held_off && sent >= RANDOM_ITEMS / 3) begin
          hold_off_req = 1'b1;
          held_off     = 1'b1;
        end
        send_request(r, 0, '0, quiet);
        sent++;
      end
    end
    // Valid is still high only when the last request had no trailing gap
    if (req_valid) req_valid <= 1'b0;

    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
